>>> hdl/qmpe_pkg.sv
// Shared constants and types for the quad max pairwise extent block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package qmpe_pkg;

  localparam int NUM_CORNERS   = 4;
  localparam int NUM_PAIRS     = 6;
  localparam int CORNER_IDX_W  = 2;
  localparam int EXTENT_WIDTH  = 17;
  localparam int MAXSQ_WIDTH   = 33;

  typedef logic [CORNER_IDX_W-1:0] corner_idx_t;

  // Corner pairs in the order (0,1) (0,2) (0,3) (1,2) (1,3) (2,3).
  localparam corner_idx_t PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam corner_idx_t PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage

>>> hdl/qmpe_if.sv
// Request and response channel interfaces for the quad max pairwise extent block.
// Depends on qmpe_pkg for the result field widths.
`timescale 1ns / 1ps

interface qmpe_req_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] p0_x;
  logic signed [COORD_WIDTH-1:0] p0_y;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    output ready
  );
endinterface

interface qmpe_rsp_if import qmpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [EXTENT_WIDTH-1:0] extent;
  logic [MAXSQ_WIDTH-1:0]  max_squared;

  modport source (
    output valid, extent, max_squared,
    input  ready
  );
  modport sink (
    input  valid, extent, max_squared,
    output ready
  );
endinterface

>>> hdl/qmpe_diff_sq.sv
// Three-stage front end: absolute coordinate differences, squares, pair sums.
// Depends on qmpe_pkg for the corner pair tables.
`timescale 1ns / 1ps

module qmpe_diff_sq import qmpe_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [COORD_WIDTH-1:0] x_i [NUM_CORNERS],
  input  logic [COORD_WIDTH-1:0] y_i [NUM_CORNERS],
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [2*COORD_WIDTH:0] d2_o [NUM_PAIRS]
);

  localparam int CW = COORD_WIDTH;
  localparam int SW = 2 * CW;
  localparam int DW = 2 * CW + 1;

  logic          dx_v_q, sq_v_q, d2_v_q;
  logic          dx_rdy, sq_rdy, d2_rdy;
  logic [CW:0]   dxs [NUM_PAIRS];
  logic [CW:0]   dys [NUM_PAIRS];
  logic [CW-1:0] adx_d [NUM_PAIRS];
  logic [CW-1:0] ady_d [NUM_PAIRS];
  logic [CW-1:0] adx_q [NUM_PAIRS];
  logic [CW-1:0] ady_q [NUM_PAIRS];
  logic [SW-1:0] sqx_q [NUM_PAIRS];
  logic [SW-1:0] sqy_q [NUM_PAIRS];
  logic [DW-1:0] d2_q  [NUM_PAIRS];

  assign d2_rdy  = !d2_v_q || ready_i;
  assign sq_rdy  = !sq_v_q || d2_rdy;
  assign dx_rdy  = !dx_v_q || sq_rdy;
  assign ready_o = dx_rdy;
  assign valid_o = d2_v_q;
  assign d2_o    = d2_q;

  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      dxs[p]   = {x_i[PAIR_A[p]][CW-1], x_i[PAIR_A[p]]} - {x_i[PAIR_B[p]][CW-1], x_i[PAIR_B[p]]};
      dys[p]   = {y_i[PAIR_A[p]][CW-1], y_i[PAIR_A[p]]} - {y_i[PAIR_B[p]][CW-1], y_i[PAIR_B[p]]};
      adx_d[p] = dxs[p][CW] ? CW'(-dxs[p]) : dxs[p][CW-1:0];
      ady_d[p] = dys[p][CW] ? CW'(-dys[p]) : dys[p][CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_v_q <= 1'b0;
      sq_v_q <= 1'b0;
      d2_v_q <= 1'b0;
    end else begin
      if (dx_rdy) dx_v_q <= valid_i;
      if (sq_rdy) sq_v_q <= dx_v_q;
      if (d2_rdy) d2_v_q <= sq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      if (dx_rdy) begin
        adx_q[p] <= adx_d[p];
        ady_q[p] <= ady_d[p];
      end
      if (sq_rdy) begin
        sqx_q[p] <= SW'(adx_q[p]) * SW'(adx_q[p]);
        sqy_q[p] <= SW'(ady_q[p]) * SW'(ady_q[p]);
      end
      if (d2_rdy) begin
        d2_q[p] <= DW'(sqx_q[p]) + DW'(sqy_q[p]);
      end
    end
  end

endmodule

>>> hdl/qmpe_max_tree.sv
// Three-stage registered maximum tree over the six pair distances.
// Depends on qmpe_pkg for the pair count.
`timescale 1ns / 1ps

module qmpe_max_tree import qmpe_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [2*COORD_WIDTH:0] d2_i [NUM_PAIRS],
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [2*COORD_WIDTH:0] best_o
);

  localparam int DW = 2 * COORD_WIDTH + 1;

  logic          l1_v_q, l2_v_q, l3_v_q;
  logic          l1_rdy, l2_rdy, l3_rdy;
  logic [DW-1:0] l1_q [3];
  logic [DW-1:0] l2_q [2];
  logic [DW-1:0] l3_q;

  assign l3_rdy  = !l3_v_q || ready_i;
  assign l2_rdy  = !l2_v_q || l3_rdy;
  assign l1_rdy  = !l1_v_q || l2_rdy;
  assign ready_o = l1_rdy;
  assign valid_o = l3_v_q;
  assign best_o  = l3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_v_q <= 1'b0;
      l2_v_q <= 1'b0;
      l3_v_q <= 1'b0;
    end else begin
      if (l1_rdy) l1_v_q <= valid_i;
      if (l2_rdy) l2_v_q <= l1_v_q;
      if (l3_rdy) l3_v_q <= l2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (l1_rdy) begin
      for (int k = 0; k < 3; k++) begin
        l1_q[k] <= (d2_i[2*k] > d2_i[2*k+1]) ? d2_i[2*k] : d2_i[2*k+1];
      end
    end
    if (l2_rdy) begin
      l2_q[0] <= (l1_q[0] > l1_q[1]) ? l1_q[0] : l1_q[1];
      l2_q[1] <= l1_q[2];
    end
    if (l3_rdy) begin
      l3_q <= (l2_q[0] > l2_q[1]) ? l2_q[0] : l2_q[1];
    end
  end

endmodule

>>> hdl/qmpe_sqrt.sv
// Floor square root pipeline, one root bit per register stage.
// Depends on qmpe_pkg for the result widths; the last stage is the output register.
`timescale 1ns / 1ps

module qmpe_sqrt import qmpe_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [2*COORD_WIDTH:0]  radicand_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [EXTENT_WIDTH-1:0] extent_o,
  output logic [MAXSQ_WIDTH-1:0]  max_squared_o
);

  localparam int DW = 2 * COORD_WIDTH + 1;
  localparam int NR = COORD_WIDTH + 1;
  localparam int TW = 2 * NR + 1;

  logic          v_q    [NR];
  logic          rdy    [NR+1];
  logic [DW-1:0] rem_q  [NR];
  logic [NR-1:0] root_q [NR];
  logic [DW-1:0] sq_q   [NR];

  assign rdy[NR]  = ready_i;
  assign ready_o  = rdy[0];
  assign valid_o  = v_q[NR-1];
  assign extent_o = EXTENT_WIDTH'(root_q[NR-1]);
  assign max_squared_o = MAXSQ_WIDTH'(sq_q[NR-1]);

  for (genvar s = 0; s < NR; s++) begin : g_stage
    localparam int B = NR - 1 - s;

    logic          v_in;
    logic [DW-1:0] rem_in, rem_d;
    logic [NR-1:0] root_in, root_d;
    logic [DW-1:0] sq_in;
    logic [TW-1:0] trial;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = radicand_i;
      assign root_in = '0;
      assign sq_in   = radicand_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign sq_in   = sq_q[s-1];
    end

    assign rdy[s] = !v_q[s] || rdy[s+1];

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    always_comb begin
      trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
      if (TW'(rem_in) >= trial) begin
        rem_d  = rem_in - DW'(trial);
        root_d = root_in | (NR'(1) << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        sq_q[s]   <= sq_in;
      end
    end
  end

endmodule

>>> hdl/quad_max_pairwise_extent.sv
// Largest corner-to-corner distance of a quadrilateral: squared value and floor root.
//
// Use: one request on req_i carries the four corners p0..p3, each coordinate a
// signed Q12.4 value of COORD_WIDTH bits. Each request gives exactly one
// response on rsp_o: max_squared, the largest squared pairwise distance in Q.8,
// and extent, its floor square root in Q.4. Both channels use valid/ready; a
// request or response moves at a clock edge with valid and ready both high.
// Pipeline: three stages for differences, squares and sums, three for the
// maximum tree, and one per root bit in the square root pipeline, whose last
// stage is the output register.
// Throughput: one request per cycle. Every stage has its own valid bit and
// loads whenever it is empty or its successor loads, so a stalled receiver
// only holds the occupied stages; empty stages keep filling and req_i.ready
// stays high until the pipeline is full.
// Reset (rst_ni low, asynchronous) clears all valid bits; no response is
// pending afterwards. The block keeps no state between requests.
// Depends on qmpe_pkg, qmpe_if, qmpe_diff_sq, qmpe_max_tree and qmpe_sqrt.
`timescale 1ns / 1ps

module quad_max_pairwise_extent import qmpe_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qmpe_req_if.sink   req_i,
  qmpe_rsp_if.source rsp_o
);

  localparam int DW = 2 * COORD_WIDTH + 1;

  logic [COORD_WIDTH-1:0] x [NUM_CORNERS];
  logic [COORD_WIDTH-1:0] y [NUM_CORNERS];
  logic [DW-1:0]          d2 [NUM_PAIRS];
  logic [DW-1:0]          best;
  logic                   ds_valid, ds_ready;
  logic                   mt_valid, mt_ready;

  assign x[0] = req_i.p0_x;
  assign y[0] = req_i.p0_y;
  assign x[1] = req_i.p1_x;
  assign y[1] = req_i.p1_y;
  assign x[2] = req_i.p2_x;
  assign y[2] = req_i.p2_y;
  assign x[3] = req_i.p3_x;
  assign y[3] = req_i.p3_y;

  qmpe_diff_sq #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_diff_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .x_i     (x),
    .y_i     (y),
    .valid_o (ds_valid),
    .ready_i (ds_ready),
    .d2_o    (d2)
  );

  qmpe_max_tree #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_max_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ds_valid),
    .ready_o (ds_ready),
    .d2_i    (d2),
    .valid_o (mt_valid),
    .ready_i (mt_ready),
    .best_o  (best)
  );

  qmpe_sqrt #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_sqrt (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (mt_valid),
    .ready_o       (mt_ready),
    .radicand_i    (best),
    .valid_o       (rsp_o.valid),
    .ready_i       (rsp_o.ready),
    .extent_o      (rsp_o.extent),
    .max_squared_o (rsp_o.max_squared)
  );

endmodule

>>> tb/qmpe_extent_checker.sv
// Passive checker for quad_max_pairwise_extent: predicts each response from the
// observed request and compares it in order. Depends on qmpe_pkg and qmpe_if.
`timescale 1ns / 1ps

module qmpe_extent_checker import qmpe_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  qmpe_req_if  req_i,
  qmpe_rsp_if  rsp_i,
  output int   mismatches_o,
  output int   outstanding_o
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [EXTENT_WIDTH-1:0] extent;
    logic [MAXSQ_WIDTH-1:0]  max_squared;
  } extent_result_t;

  extent_result_t extents_due [$];
  extent_result_t want;
  coord_t         xs [NUM_CORNERS];
  coord_t         ys [NUM_CORNERS];
  int             mismatch_cnt;
  int             due_cnt;

  assign mismatches_o  = mismatch_cnt;
  assign outstanding_o = due_cnt;

  // Exact squared distances, then a bitwise floor root.
  function automatic extent_result_t predict_extent(input coord_t px [NUM_CORNERS],
                                                    input coord_t py [NUM_CORNERS]);
    longint         dx;
    longint         dy;
    bit [63:0]      d2;
    bit [63:0]      widest;
    bit [63:0]      root;
    bit [63:0]      trial;
    extent_result_t r;
    widest = '0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      for (int j = i + 1; j < NUM_CORNERS; j++) begin
        dx = longint'(px[i]) - longint'(px[j]);
        dy = longint'(py[i]) - longint'(py[j]);
        d2 = 64'(dx * dx + dy * dy);
        if (d2 > widest) begin
          widest = d2;
        end
      end
    end
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= widest) begin
        root = trial;
      end
    end
    r.max_squared = widest[MAXSQ_WIDTH-1:0];
    r.extent      = root[EXTENT_WIDTH-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extents_due.delete();
      mismatch_cnt = 0;
      due_cnt      = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        xs[0] = req_i.p0_x;  ys[0] = req_i.p0_y;
        xs[1] = req_i.p1_x;  ys[1] = req_i.p1_y;
        xs[2] = req_i.p2_x;  ys[2] = req_i.p2_y;
        xs[3] = req_i.p3_x;  ys[3] = req_i.p3_y;
        extents_due.insert(extents_due.size(), predict_extent(xs, ys));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (extents_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%t: response with no request pending: extent %0d max_squared %0d",
                     $realtime, rsp_i.extent, rsp_i.max_squared);
          end
        end else begin
          want = extents_due.pop_front();
          if (rsp_i.extent !== want.extent || rsp_i.max_squared !== want.max_squared) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%t: mismatch: extent exp %0d got %0d, max_squared exp %0d got %0d",
                       $realtime, want.extent, rsp_i.extent,
                       want.max_squared, rsp_i.max_squared);
            end
          end
        end
      end
      due_cnt = extents_due.size();
    end
  end

endmodule

>>> tb/tb_quad_max_pairwise_extent.sv
// Testbench top for quad_max_pairwise_extent: clock, reset, request and response
// drivers with random gaps and two long receiver stalls. Depends on qmpe_pkg,
// qmpe_if, the block and qmpe_extent_checker.
`timescale 1ns / 1ps

module tb_quad_max_pairwise_extent;
  import qmpe_pkg::*;

  localparam int COORD_W      = 16;
  localparam int NUM_RANDOM   = 450;
  localparam int STALL_LONG   = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t quad_t [2*NUM_CORNERS];

  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   tx_burst;
  bit   rx_burst;
  int   rsp_seen;
  int   cycle_cnt;
  int   mismatches;
  int   outstanding;

  qmpe_req_if #(.COORD_WIDTH(COORD_W)) req_ch ();
  qmpe_rsp_if                          rsp_ch ();

  quad_max_pairwise_extent #(.COORD_WIDTH(COORD_W)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  qmpe_extent_checker #(.COORD_WIDTH(COORD_W)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_quad_max_pairwise_extent: done, errors");
      $finish;
    end
  end

  task automatic send_quad(input quad_t q);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.p0_x  <= q[0];
    req_ch.p0_y  <= q[1];
    req_ch.p1_x  <= q[2];
    req_ch.p1_y  <= q[3];
    req_ch.p2_x  <= q[4];
    req_ch.p2_y  <= q[5];
    req_ch.p3_x  <= q[6];
    req_ch.p3_y  <= q[7];
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic make_random_quad(output quad_t q);
    int mode;
    int cx;
    int cy;
    int src;
    int dst;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 2*NUM_CORNERS; i++) begin
      q[i] = coord_t'($urandom);
    end
    if (mode >= 4 && mode <= 6) begin
      // plausible quad: corners spread around a center
      cx = int'($urandom_range(0, 32000)) - 16000;
      cy = int'($urandom_range(0, 32000)) - 16000;
      for (int i = 0; i < NUM_CORNERS; i++) begin
        q[2*i]   = coord_t'(cx + int'($urandom_range(0, 8000)) - 4000);
        q[2*i+1] = coord_t'(cy + int'($urandom_range(0, 8000)) - 4000);
      end
    end else if (mode == 7 || mode == 8) begin
      for (int i = 0; i < 2*NUM_CORNERS; i++) begin
        case ($urandom_range(0, 4))
          0: q[i] = C_MIN;
          1: q[i] = C_MAX;
          2: q[i] = '0;
          3: q[i] = '1;
          default: q[i] = coord_t'($urandom);
        endcase
      end
    end else if (mode == 9) begin
      // coincident corners
      src = $urandom_range(0, NUM_CORNERS-1);
      dst = $urandom_range(0, NUM_CORNERS-1);
      q[2*dst]   = q[2*src];
      q[2*dst+1] = q[2*src+1];
    end
  endtask

  initial begin : rsp_side
    int hold;
    rsp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rsp_seen % 32 == 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      hold = rx_burst ? 0 : $urandom_range(0, 4);
      if (rsp_seen == 60 || rsp_seen == 320) begin
        hold = STALL_LONG;
      end
      repeat (hold) begin
        @(negedge clk_i);
        rsp_ch.ready <= 1'b0;
      end
      @(negedge clk_i);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      rsp_seen++;
    end
  end

  initial begin : req_side
    quad_t q;
    req_ch.valid = 1'b0;
    req_ch.p0_x  = '0;
    req_ch.p0_y  = '0;
    req_ch.p1_x  = '0;
    req_ch.p1_y  = '0;
    req_ch.p2_x  = '0;
    req_ch.p2_y  = '0;
    req_ch.p3_x  = '0;
    req_ch.p3_y  = '0;
    tx_burst     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all corners coincident
    q = '{default: '0};
    send_quad(q);
    q = '{default: C_MIN};
    send_quad(q);
    q = '{default: C_MAX};
    send_quad(q);
    // widest possible span, on each pair in turn
    for (int p = 0; p < NUM_PAIRS; p++) begin
      q = '{default: '0};
      q[2*PAIR_A[p]]   = C_MIN;
      q[2*PAIR_A[p]+1] = C_MAX;
      q[2*PAIR_B[p]]   = C_MAX;
      q[2*PAIR_B[p]+1] = C_MIN;
      send_quad(q);
    end
    q = '{C_MIN, C_MIN, C_MAX, C_MAX, '0, '0, '0, '0};
    send_quad(q);
    // square: ties between both diagonals
    q = '{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd16, 16'sd16, 16'sd0, 16'sd16};
    send_quad(q);
    // spread along one axis only
    q = '{C_MIN, 16'sd0, C_MAX, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_quad(q);
    q = '{16'sd0, C_MIN, 16'sd0, C_MAX, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_quad(q);
    // small values around the root's rounding
    q = '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_quad(q);
    q = '{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0};
    send_quad(q);
    q = '{16'sd0, 16'sd0, 16'sd3, 16'sd4, 16'sd1, 16'sd1, 16'sd2, 16'sd2};
    send_quad(q);
    q = '{-16'sd2, -16'sd2, 16'sd2, 16'sd2, 16'sd0, 16'sd0, 16'sd1, 16'sd0};
    send_quad(q);
    q = '{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh5555, 16'sh5555,
          16'shAAAA, 16'shAAAA};
    send_quad(q);
    q = '{-16'sd1, -16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, -16'sd1};
    send_quad(q);

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k % 32 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
      end
      make_random_quad(q);
      send_quad(q);
    end
    @(negedge clk_i);
    req_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_quad_max_pairwise_extent: done, clean");
    end else begin
      $display("tb_quad_max_pairwise_extent: done, errors");
    end
    $finish;
  end

endmodule
